>>> src/fmibs_pkg.sv
// Shared types and constants for the FM-index backward search block.
`default_nettype none
package fmibs_pkg;

    localparam int RANGE_W  = 17;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;
    localparam int SYM_W    = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_INC,
        S_CKPT,
        S_LT,
        S_CTAB,
        S_DIV,
        S_CKRD,
        S_CKWAIT,
        S_WALK,
        S_FIN,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

>>> src/fmibs_if.sv
// Valid/ready channel interfaces for command input and search results.
`default_nettype none
interface fmibs_in_if;
    logic                         valid;
    logic                         ready;
    logic [fmibs_pkg::CMD_W-1:0]  command;
    logic [fmibs_pkg::SYM_W-1:0]  symbol;
    modport source (output valid, output command, output symbol, input ready);
    modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface fmibs_out_if;
    logic                            valid;
    logic                            ready;
    logic [fmibs_pkg::RANGE_W-1:0]   range_start;
    logic [fmibs_pkg::RANGE_W-1:0]   range_end;
    logic [fmibs_pkg::RANGE_W-1:0]   match_count;
    logic [fmibs_pkg::STATUS_W-1:0]  status;
    modport source (output valid, output range_start, output range_end,
                    output match_count, output status, input ready);
    modport sink   (input valid, input range_start, input range_end,
                    input match_count, input status, output ready);
endinterface
`default_nettype wire

>>> src/fmibs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fmibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/fm_index_backward_search.sv
// Top level of the FM-index backward search engine.
// Takes one command at a time. A text byte load is followed, every
// CHECKPOINT_INTERVAL bytes, by a sweep that snapshots all counts into
// the checkpoint memory. Finish builds the less-than table and posts the
// range. A pattern byte runs two ranks, each a reciprocal multiplication
// of the position for the checkpoint index, a checkpoint read and a walk
// over up to CHECKPOINT_INTERVAL-1 stored bytes at one byte per cycle on
// the text memory read port.
// Results sit in an output register, so the next command is taken while
// a result waits. No clearing pass follows reset.
`default_nettype none
module fm_index_backward_search #(
    parameter int MAX_TEXT            = 65536,
    parameter int CHECKPOINT_INTERVAL = 256,
    parameter int ALPHABET_SIZE       = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fmibs_in_if.sink    i_in,
    fmibs_out_if.source o_out
);
    import fmibs_pkg::*;

    localparam int CW       = $clog2(MAX_TEXT + 1);
    localparam int AW       = $clog2(MAX_TEXT);
    localparam int IW       = $clog2(CHECKPOINT_INTERVAL + 1);
    localparam int ABITS    = $clog2(ALPHABET_SIZE);
    localparam int SW       = $clog2(ALPHABET_SIZE + 1);
    localparam int NUM_CKPT = MAX_TEXT / CHECKPOINT_INTERVAL;
    localparam int KW       = (NUM_CKPT > 1) ? $clog2(NUM_CKPT) : 1;
    localparam int CKAW     = KW + ABITS;
    localparam int RSH      = CW + $clog2(CHECKPOINT_INTERVAL);
    localparam int MW       = CW + 1;
    localparam longint unsigned RMUL =
        ((longint'(1) << RSH) + longint'(CHECKPOINT_INTERVAL) - 1)
        / longint'(CHECKPOINT_INTERVAL);

    t_state r_state, n_state;

    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [CW-1:0]       r_len, n_len;
    logic [CW-1:0]       r_low, n_low;
    logic [CW-1:0]       r_high, n_high;
    logic                r_ready, n_ready;
    logic                r_ovf, n_ovf;
    logic [IW-1:0]       r_phase, n_phase;
    logic [CW-1:0]       r_ck_k, n_ck_k;
    logic [SW-1:0]       r_sw_c, n_sw_c;
    logic                r_sw_pend, n_sw_pend;
    logic [ABITS-1:0]    r_sw_dc, n_sw_dc;
    logic [CW-1:0]       r_sum, n_sum;
    logic [CW-1:0]       r_ctab, n_ctab;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_rsel, n_rsel;
    logic [CW-1:0]       r_quo, n_quo;
    logic                r_use_ck, n_use_ck;
    logic [CW-1:0]       r_wi, n_wi;
    logic [IW-1:0]       r_wleft, n_wleft;
    logic                r_wpend, n_wpend;
    logic [CW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_rlo, n_rlo;
    logic [CW-1:0]       r_res_lo, n_res_lo;
    logic [CW-1:0]       r_res_hi, n_res_hi;
    logic [STATUS_W-1:0] r_res_st, n_res_st;
    logic                r_ov, n_ov;
    logic [RANGE_W-1:0]  r_o_start, n_o_start;
    logic [RANGE_W-1:0]  r_o_end, n_o_end;
    logic [RANGE_W-1:0]  r_o_count, n_o_count;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic                r_rc_valid [ALPHABET_SIZE];
    logic                n_rc_set;
    logic [ABITS-1:0]    n_rc_set_idx;

    logic                txt_we;
    logic [AW-1:0]       txt_waddr, txt_raddr;
    logic [SYM_W-1:0]    txt_rdata;
    logic                rc_we;
    logic [ABITS-1:0]    rc_waddr, rc_raddr;
    logic [CW-1:0]       rc_wdata, rc_rdata;
    logic                lt_we;
    logic [ABITS-1:0]    lt_waddr, lt_raddr;
    logic [CW-1:0]       lt_wdata, lt_rdata;
    logic                ck_we;
    logic [CKAW-1:0]     ck_waddr, ck_raddr;
    logic [CW-1:0]       ck_wdata, ck_rdata;

    logic                acc;
    logic                sym_bad;
    logic                full;
    logic                phase_wrap;
    logic                sw_done;
    logic                walk_done;
    logic [CW+MW-1:0]    quo_prod;
    logic [CW+IW-1:0]    base_prod;
    logic [CW-1:0]       base_pos;
    logic [CW-1:0]       sw_val;
    logic [CW-1:0]       ld_val;
    logic [CW-1:0]       fin_lo, fin_hi;
    logic                out_free;

    fmibs_ram #(.WIDTH(SYM_W), .DEPTH(2 ** AW)) u_txt (
        .i_clk(i_clk), .i_we(txt_we), .i_waddr(txt_waddr), .i_wdata(r_sym),
        .i_raddr(txt_raddr), .o_rdata(txt_rdata)
    );
    fmibs_ram #(.WIDTH(CW), .DEPTH(2 ** ABITS)) u_rc (
        .i_clk(i_clk), .i_we(rc_we), .i_waddr(rc_waddr), .i_wdata(rc_wdata),
        .i_raddr(rc_raddr), .o_rdata(rc_rdata)
    );
    fmibs_ram #(.WIDTH(CW), .DEPTH(2 ** ABITS)) u_lt (
        .i_clk(i_clk), .i_we(lt_we), .i_waddr(lt_waddr), .i_wdata(lt_wdata),
        .i_raddr(lt_raddr), .o_rdata(lt_rdata)
    );
    fmibs_ram #(.WIDTH(CW), .DEPTH(2 ** CKAW)) u_ck (
        .i_clk(i_clk), .i_we(ck_we), .i_waddr(ck_waddr), .i_wdata(ck_wdata),
        .i_raddr(ck_raddr), .o_rdata(ck_rdata)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign acc           = i_in.valid && (r_state == S_IDLE);
    assign sym_bad       = ({1'b0, i_in.symbol} >= (SYM_W + 1)'(ALPHABET_SIZE));
    assign full          = (r_len >= CW'(MAX_TEXT));
    assign phase_wrap    = (r_phase == IW'(CHECKPOINT_INTERVAL - 1));
    assign sw_done       = (r_sw_c == SW'(ALPHABET_SIZE)) && !r_sw_pend;
    assign walk_done     = (r_wleft == '0) && !r_wpend;
    assign quo_prod      = r_pos * MW'(RMUL);
    assign base_prod     = r_quo * IW'(CHECKPOINT_INTERVAL);
    assign base_pos      = base_prod[CW-1:0];
    assign sw_val        = r_rc_valid[r_sw_dc] ? rc_rdata : '0;
    assign ld_val        = r_rc_valid[r_sym[ABITS-1:0]] ? rc_rdata : '0;
    assign fin_lo        = r_ctab + r_rlo;
    assign fin_hi        = r_ctab + r_total;
    assign out_free      = !r_ov || o_out.ready;

    assign o_out.valid       = r_ov;
    assign o_out.range_start = r_o_start;
    assign o_out.range_end   = r_o_end;
    assign o_out.match_count = r_o_count;
    assign o_out.status      = r_o_status;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_in.command)
                        CMD_LOAD: begin
                            n_state = (sym_bad || full) ? S_OUT : S_LOAD_INC;
                        end
                        CMD_FINISH: n_state = S_LT;
                        CMD_START:  n_state = S_OUT;
                        default: begin
                            if (!r_ready || sym_bad || (r_low >= r_high)) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_CTAB;
                            end
                        end
                    endcase
                end
            end
            S_LOAD_INC: n_state = phase_wrap ? S_CKPT : S_IDLE;
            S_CKPT:     n_state = sw_done ? S_IDLE : S_CKPT;
            S_LT:       n_state = sw_done ? S_OUT : S_LT;
            S_CTAB:     n_state = S_DIV;
            S_DIV:      n_state = S_CKRD;
            S_CKRD:     n_state = S_CKWAIT;
            S_CKWAIT:   n_state = S_WALK;
            S_WALK: begin
                if (walk_done) begin
                    n_state = r_rsel ? S_FIN : S_DIV;
                end
            end
            S_FIN:      n_state = S_OUT;
            S_OUT:      n_state = out_free ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_sym = r_sym;         n_len = r_len;         n_low = r_low;
        n_high = r_high;       n_ready = r_ready;     n_ovf = r_ovf;
        n_phase = r_phase;     n_ck_k = r_ck_k;       n_sw_c = r_sw_c;
        n_sw_pend = r_sw_pend; n_sw_dc = r_sw_dc;     n_sum = r_sum;
        n_ctab = r_ctab;       n_pos = r_pos;         n_rsel = r_rsel;
        n_quo = r_quo;
        n_use_ck = r_use_ck;   n_wi = r_wi;           n_wleft = r_wleft;
        n_wpend = r_wpend;     n_total = r_total;     n_rlo = r_rlo;
        n_res_lo = r_res_lo;   n_res_hi = r_res_hi;   n_res_st = r_res_st;
        n_ov = r_ov;           n_o_start = r_o_start; n_o_end = r_o_end;
        n_o_count = r_o_count; n_o_status = r_o_status;
        n_rc_set = 1'b0;       n_rc_set_idx = r_sym[ABITS-1:0];
        txt_we = 1'b0;         txt_waddr = r_len[AW-1:0];
        txt_raddr = r_wi[AW-1:0];
        rc_we = 1'b0;          rc_waddr = r_sym[ABITS-1:0];
        rc_wdata = ld_val + CW'(1);
        rc_raddr = r_sw_c[ABITS-1:0];
        lt_we = 1'b0;          lt_waddr = r_sw_dc;    lt_wdata = r_sum;
        lt_raddr = i_in.symbol[ABITS-1:0];
        ck_we = 1'b0;          ck_waddr = {KW'(r_ck_k - CW'(1)), r_sw_dc};
        ck_wdata = sw_val;
        ck_raddr = {KW'(r_quo - CW'(1)), r_sym[ABITS-1:0]};

        if (o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_sym    = i_in.symbol;
                    n_res_lo = '0;
                    n_res_hi = '0;
                    n_res_st = ST_OK;
                    case (i_in.command)
                        CMD_LOAD: begin
                            n_res_st = ST_OVERFLOW;
                            if (!sym_bad && full) begin
                                n_ovf = 1'b1;
                            end
                            if (!sym_bad && !full) begin
                                rc_raddr = i_in.symbol[ABITS-1:0];
                            end
                        end
                        CMD_FINISH: begin
                            n_sw_c    = '0;
                            n_sw_pend = 1'b0;
                            n_sum     = '0;
                        end
                        CMD_START: begin
                            if (!r_ready) begin
                                n_res_st = ST_NOT_LOADED;
                            end else begin
                                n_low    = '0;
                                n_high   = r_len;
                                n_res_hi = r_len;
                            end
                        end
                        default: begin
                            if (!r_ready) begin
                                n_res_st = ST_NOT_LOADED;
                            end else if (sym_bad || (r_low >= r_high)) begin
                                n_low  = '0;
                                n_high = '0;
                            end
                        end
                    endcase
                end
            end
            S_LOAD_INC: begin
                txt_we   = 1'b1;
                rc_we    = 1'b1;
                n_rc_set = 1'b1;
                n_len    = r_len + CW'(1);
                n_ready  = 1'b0;
                n_sw_c    = '0;
                n_sw_pend = 1'b0;
                if (phase_wrap) begin
                    n_phase = '0;
                    n_ck_k  = r_ck_k + CW'(1);
                end else begin
                    n_phase = r_phase + IW'(1);
                end
            end
            S_CKPT, S_LT: begin
                if (r_sw_c != SW'(ALPHABET_SIZE)) begin
                    n_sw_c    = r_sw_c + SW'(1);
                    n_sw_pend = 1'b1;
                    n_sw_dc   = r_sw_c[ABITS-1:0];
                end else begin
                    n_sw_pend = 1'b0;
                end
                if (r_sw_pend) begin
                    if (r_state == S_CKPT) begin
                        ck_we = 1'b1;
                    end else begin
                        lt_we = 1'b1;
                        n_sum = r_sum + sw_val;
                    end
                end
                if ((r_state == S_LT) && sw_done) begin
                    n_ready  = 1'b1;
                    n_low    = '0;
                    n_high   = r_len;
                    n_res_lo = '0;
                    n_res_hi = r_len;
                    n_res_st = r_ovf ? ST_OVERFLOW : ST_OK;
                end
            end
            S_CTAB: begin
                n_ctab = lt_rdata;
                n_pos  = r_low;
                n_rsel = 1'b0;
            end
            S_DIV: begin
                n_quo = CW'(quo_prod >> RSH);
            end
            S_CKRD: begin
                n_use_ck = (r_quo != '0) && (r_quo <= CW'(NUM_CKPT));
                n_wi     = base_pos;
                n_wleft  = IW'(r_pos - base_pos);
                n_wpend  = 1'b0;
            end
            S_CKWAIT: begin
                n_total = r_use_ck ? ck_rdata : '0;
            end
            S_WALK: begin
                if (r_wleft != '0) begin
                    n_wi    = r_wi + CW'(1);
                    n_wleft = r_wleft - IW'(1);
                    n_wpend = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                end
                if (r_wpend && (txt_rdata == r_sym)) begin
                    n_total = r_total + CW'(1);
                end
                if (walk_done && !r_rsel) begin
                    n_rlo  = r_total;
                    n_rsel = 1'b1;
                    n_pos  = r_high;
                end
            end
            S_FIN: begin
                n_res_st = ST_OK;
                if (fin_lo >= fin_hi) begin
                    n_low    = '0;
                    n_high   = '0;
                    n_res_lo = '0;
                    n_res_hi = '0;
                end else begin
                    n_low    = fin_lo;
                    n_high   = fin_hi;
                    n_res_lo = fin_lo;
                    n_res_hi = fin_hi;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_start  = RANGE_W'(r_res_lo);
                    n_o_end    = RANGE_W'(r_res_hi);
                    n_o_count  = RANGE_W'(r_res_hi - r_res_lo);
                    n_o_status = r_res_st;
                end
            end
            default: begin
                n_ov = r_ov;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_low   <= '0;
            r_high  <= '0;
            r_ready <= 1'b0;
            r_ovf   <= 1'b0;
            r_phase <= '0;
            r_ck_k  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                r_rc_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_low   <= n_low;
            r_high  <= n_high;
            r_ready <= n_ready;
            r_ovf   <= n_ovf;
            r_phase <= n_phase;
            r_ck_k  <= n_ck_k;
            r_ov    <= n_ov;
            if (n_rc_set) begin
                r_rc_valid[n_rc_set_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_sw_c     <= n_sw_c;
        r_sw_pend  <= n_sw_pend;
        r_sw_dc    <= n_sw_dc;
        r_sum      <= n_sum;
        r_ctab     <= n_ctab;
        r_pos      <= n_pos;
        r_rsel     <= n_rsel;
        r_quo      <= n_quo;
        r_use_ck   <= n_use_ck;
        r_wi       <= n_wi;
        r_wleft    <= n_wleft;
        r_wpend    <= n_wpend;
        r_total    <= n_total;
        r_rlo      <= n_rlo;
        r_res_lo   <= n_res_lo;
        r_res_hi   <= n_res_hi;
        r_res_st   <= n_res_st;
        r_o_start  <= n_o_start;
        r_o_end    <= n_o_end;
        r_o_count  <= n_o_count;
        r_o_status <= n_o_status;
    end
endmodule
`default_nettype wire

>>> src/fmibs_checker.sv
// Port-level checks on the search result channel, bound to the top level.
`default_nettype none
module fmibs_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                i_ready,
    input wire logic [fmibs_pkg::RANGE_W-1:0]       i_start,
    input wire logic [fmibs_pkg::RANGE_W-1:0]       i_end,
    input wire logic [fmibs_pkg::RANGE_W-1:0]       i_count,
    input wire logic [fmibs_pkg::STATUS_W-1:0]      i_status
);
    import fmibs_pkg::*;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_count == RANGE_W'(i_end - i_start)))
        else $error("match count differs from range width");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status == ST_OK || i_status == ST_NOT_LOADED
                     || i_status == ST_OVERFLOW))
        else $error("undefined status code");

    a_notld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_NOT_LOADED)) |->
        (i_start == '0 && i_end == '0))
        else $error("not-loaded result carries a range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
        (i_valid && $stable(i_start) && $stable(i_end) && $stable(i_status)))
        else $error("stalled result changed");
endmodule

bind fm_index_backward_search fmibs_checker u_fmibs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_start (o_out.range_start),
    .i_end   (o_out.range_end),
    .i_count (o_out.match_count),
    .i_status(o_out.status)
);
`default_nettype wire
